// File: rtl/double_to_q31_multiplier_core_defines.svh
// assertion macros for the double to q31 multiplier core
// no dependencies; included by the rtl files that carry assertions
`ifndef DOUBLE_TO_Q31_MULTIPLIER_CORE_DEFINES_SVH
`define DOUBLE_TO_Q31_MULTIPLIER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DQ31_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dq31 assertion failed");

// next-cycle implication, disabled while in reset
`define DQ31_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dq31 assertion failed");

`endif

// File: rtl/dq31_pkg.sv
// shared constants, types and helpers for the double to q31 multiplier core
// no dependencies
package dq31_pkg;

  localparam int VALUE_W       = 64;
  localparam int MANT_W        = 32;
  localparam int EXP_W         = 12;
  localparam int FRAC_BITS     = 52;
  localparam int BEXP_W        = 11;
  localparam int SH_W          = 6;
  localparam int EXP_BIAS      = 1022;
  localparam int MANT_BITS_DEF = 31;

  localparam logic [BEXP_W-1:0] EXP_ALL1 = 11'h7ff;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FIN  = 2'd0;
  localparam kind_t KIND_ZERO = 2'd1;
  localparam kind_t KIND_INF  = 2'd2;
  localparam kind_t KIND_NAN  = 2'd3;

  // leading zeros of the fraction field (value for all-zero is don't care)
  function automatic logic [SH_W-1:0] frac_lzc(input logic [FRAC_BITS-1:0] f);
    logic [SH_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (f[i]) begin
        cnt = SH_W'(FRAC_BITS - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// File: rtl/double_to_q31_multiplier_core.sv
// double to q31 multiplier core: binary64 bit pattern to signed mantissa and shift
// depends on dq31_pkg and double_to_q31_multiplier_core_defines.svh
//
//  port group  | direction | contents
//  in_*        | sink      | in_value_bits (64b binary64 pattern), valid/ready
//  out_*       | source    | out_mantissa_q31 (32b signed), out_exponent_shift (12b signed)
//
// one word per cycle unless out_ready low holds the pipeline; results leave in input order
// stages: input register, leading-zero count, normalise shift and round, result register
// each stage moves when the one after it is empty or moving, so in_ready only
// drops when all four registers hold words and out_ready is low
// rst_n (synchronous) empties the pipeline; payload registers are not reset
`include "double_to_q31_multiplier_core_defines.svh"

module double_to_q31_multiplier_core
  import dq31_pkg::*;
#(
  parameter int MANT_BITS = MANT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_W-1:0]       in_value_bits,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MANT_W-1:0] out_mantissa_q31,
  output logic signed [EXP_W-1:0]  out_exponent_shift
);

  localparam int SIG_W = FRAC_BITS + 1;
  localparam int RND_W = MANT_BITS + 1;

  // pipeline valids and enables
  logic in_v_r, a_v_r, b_v_r, out_v_r;
  logic en_in, en_a, en_b, en_out;

  assign en_out   = !out_v_r || out_ready;
  assign en_b     = !b_v_r || en_out;
  assign en_a     = !a_v_r || en_b;
  assign en_in    = !in_v_r || en_a;
  assign in_ready = en_in;
  assign out_valid = out_v_r;

  // input register
  logic [VALUE_W-1:0] in_bits_r;

  // stage a: classify and count leading zeros
  logic                    sign_a;
  logic [BEXP_W-1:0]       bexp_a;
  logic [FRAC_BITS-1:0]    frac_a;
  logic [SH_W-1:0]         lz_a;
  kind_t                   kind_nxt;
  logic [SIG_W-1:0]        sig_nxt;
  logic [SH_W-1:0]         sh_nxt;
  logic signed [EXP_W-1:0] expo_a_nxt;

  always_comb begin
    sign_a     = in_bits_r[VALUE_W-1];
    bexp_a     = in_bits_r[VALUE_W-2:FRAC_BITS];
    frac_a     = in_bits_r[FRAC_BITS-1:0];
    lz_a       = frac_lzc(frac_a);
    sig_nxt    = {(bexp_a != '0), frac_a};
    sh_nxt     = '0;
    expo_a_nxt = EXP_W'({1'b0, bexp_a}) - EXP_W'(EXP_BIAS);
    if (bexp_a == '0) begin
      // subnormal: move the leading one up to the hidden bit position
      sh_nxt     = lz_a + SH_W'(1);
      expo_a_nxt = -EXP_W'(EXP_BIAS) - EXP_W'(lz_a);
    end
    if (in_bits_r[VALUE_W-2:0] == '0) begin
      kind_nxt = KIND_ZERO;
    end else if (bexp_a == EXP_ALL1) begin
      kind_nxt = (frac_a == '0) ? KIND_INF : KIND_NAN;
    end else begin
      kind_nxt = KIND_FIN;
    end
  end

  logic                    a_sign_r;
  kind_t                   a_kind_r;
  logic [SIG_W-1:0]        a_sig_r;
  logic [SH_W-1:0]         a_sh_r;
  logic signed [EXP_W-1:0] a_expo_r;

  // stage b: normalise and round half-up
  logic [SIG_W-1:0]     sig_sh;
  logic [MANT_BITS:0]   sig_top;
  logic [MANT_BITS+1:0] rsum;
  logic [RND_W-1:0]     rnd_nxt;

  always_comb begin
    sig_sh  = a_sig_r << a_sh_r;
    sig_top = sig_sh[FRAC_BITS -: MANT_BITS+1];
    rsum    = {1'b0, sig_top} + {{(MANT_BITS+1){1'b0}}, 1'b1};
    rnd_nxt = rsum[MANT_BITS+1:1];
  end

  logic                    b_sign_r;
  kind_t                   b_kind_r;
  logic [RND_W-1:0]        b_rnd_r;
  logic signed [EXP_W-1:0] b_expo_r;

  // stage c: carry fix-up, sign and special values
  logic                    carry;
  logic [MANT_BITS-1:0]    mag;
  logic [MANT_W-1:0]       mag_w;
  logic signed [MANT_W-1:0] mant_nxt;
  logic signed [EXP_W-1:0]  expo_nxt;

  always_comb begin
    carry = b_rnd_r[MANT_BITS];
    mag   = carry ? b_rnd_r[MANT_BITS:1] : b_rnd_r[MANT_BITS-1:0];
    mag_w = {{(MANT_W-MANT_BITS){1'b0}}, mag};
    case (b_kind_r)
      KIND_FIN: begin
        mant_nxt = b_sign_r ? (MANT_W'(0) - mag_w) : mag_w;
        expo_nxt = b_expo_r + {{(EXP_W-1){1'b0}}, carry};
      end
      KIND_INF: begin
        mant_nxt = b_sign_r ? {1'b1, {(MANT_W-1){1'b0}}} : {1'b0, {(MANT_W-1){1'b1}}};
        expo_nxt = '0;
      end
      default: begin
        mant_nxt = '0;
        expo_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_in)  in_v_r  <= in_valid;
      if (en_a)   a_v_r   <= in_v_r;
      if (en_b)   b_v_r   <= a_v_r;
      if (en_out) out_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && in_valid) begin
      in_bits_r <= in_value_bits;
    end
    if (en_a && in_v_r) begin
      a_sign_r <= sign_a;
      a_kind_r <= kind_nxt;
      a_sig_r  <= sig_nxt;
      a_sh_r   <= sh_nxt;
      a_expo_r <= expo_a_nxt;
    end
    if (en_b && a_v_r) begin
      b_sign_r <= a_sign_r;
      b_kind_r <= a_kind_r;
      b_rnd_r  <= rnd_nxt;
      b_expo_r <= a_expo_r;
    end
    if (en_out && b_v_r) begin
      out_mantissa_q31   <= mant_nxt;
      out_exponent_shift <= expo_nxt;
    end
  end

  // leading-zero count must bring the top one to the hidden bit
  `DQ31_ASSERT_NOW(a_norm_chk, clk, rst_n, a_v_r && (a_kind_r == KIND_FIN), sig_sh[FRAC_BITS])
  // rounded magnitude keeps its top bit or carries out
  `DQ31_ASSERT_NOW(b_rnd_chk, clk, rst_n, b_v_r && (b_kind_r == KIND_FIN),
                   b_rnd_r[MANT_BITS] || b_rnd_r[MANT_BITS-1])
  // a zero mantissa only comes with a zero shift
  `DQ31_ASSERT_NOW(out_zero_chk, clk, rst_n, out_valid && (out_mantissa_q31 == '0),
                   out_exponent_shift == '0)
  // a full, stalled pipeline takes no new word
  `DQ31_ASSERT_NOW(full_stall_chk, clk, rst_n,
                   in_v_r && a_v_r && b_v_r && out_v_r && !out_ready, !in_ready)
  // a word in stage b reaches the result register when it is free
  `DQ31_ASSERT_NEXT(b_move_chk, clk, rst_n, b_v_r && en_out, out_v_r)

endmodule
